[rtl/sorted_priority_queue_assert.svh]
// Assertion macros used by the checker file.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, muted while reset is high.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

   // operation codes carried in req_tuser
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   // occupancy state of the controller
   typedef enum logic [2:0] {
      ST_EMPTY = 3'b001,
      ST_PART  = 3'b010,
      ST_FULL  = 3'b100
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic insert;
      logic remove;
   } cmd_type;

endpackage

[rtl/spq_ctrl.sv]
`timescale 1ns / 1ps

module spq_ctrl
   import spq_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_mode,
   output logic          req_ready,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic          rsp_ok,
   output logic [CW-1:0] count,
   output logic          full,
   output logic          empty,
   output cmd_type       dp_cmd
);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          ok_ff, ok_in;
   logic          accept;

   // output register frees up when empty or being drained this cycle
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      dp_cmd       = '0;
      ok_in        = ok_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         unique case (req_mode)
            MODE_INSERT: begin
               ok_in = (state_ff != ST_FULL);
               dp_cmd.insert = ok_in;
               if (ok_in) count_in = count_ff + 1'b1;
            end
            MODE_REMOVE: begin
               ok_in = (state_ff != ST_EMPTY);
               dp_cmd.remove = ok_in;
               if (ok_in) count_in = count_ff - 1'b1;
            end
            default: begin
               // query, and the unused code: no change
               ok_in = (state_ff != ST_EMPTY);
            end
         endcase
      end
      priority if (count_in == '0) begin
         state_in = ST_EMPTY;
      end else if (count_in == CW'(DEPTH)) begin
         state_in = ST_FULL;
      end else begin
         state_in = ST_PART;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EMPTY;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) ok_ff <= ok_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = ok_ff;
   assign count     = count_ff;
   assign full      = (state_ff == ST_FULL);
   assign empty     = (state_ff == ST_EMPTY);

endmodule

[rtl/spq_datapath.sv]
`timescale 1ns / 1ps

module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int PRIO_BITS = 8,
   parameter int TAG_BITS  = 16,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  cmd_type              dp_cmd,
   input  logic [CW-1:0]        count,
   input  logic [PRIO_BITS-1:0] req_prio,
   input  logic [TAG_BITS-1:0]  req_tag,
   output logic [PRIO_BITS-1:0] head_prio,
   output logic [TAG_BITS-1:0]  head_tag
);

   // slots held in descending priority, head at slot 0
   logic [PRIO_BITS-1:0] prio_ff [DEPTH];
   logic [TAG_BITS-1:0]  tag_ff  [DEPTH];
   logic [PRIO_BITS-1:0] prio_in [DEPTH];
   logic [TAG_BITS-1:0]  tag_in  [DEPTH];
   logic [DEPTH-1:0]     keep;

   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      logic [PRIO_BITS-1:0] ins_prio, up_prio;
      logic [TAG_BITS-1:0]  ins_tag, up_tag;

      // held entry at or above the new priority stays where it is
      assign keep[i] = (CW'(i) < count) && (prio_ff[i] >= req_prio);

      if (i == 0) begin : g_first
         assign ins_prio = req_prio;
         assign ins_tag  = req_tag;
      end else begin : g_rest
         assign ins_prio = keep[i-1] ? req_prio : prio_ff[i-1];
         assign ins_tag  = keep[i-1] ? req_tag  : tag_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign up_prio = prio_ff[i];
         assign up_tag  = tag_ff[i];
      end else begin : g_mid
         assign up_prio = prio_ff[i+1];
         assign up_tag  = tag_ff[i+1];
      end

      assign prio_in[i] = dp_cmd.remove ? up_prio : (keep[i] ? prio_ff[i] : ins_prio);
      assign tag_in[i]  = dp_cmd.remove ? up_tag  : (keep[i] ? tag_ff[i]  : ins_tag);
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.insert || dp_cmd.remove) begin
         prio_ff <= prio_in;
         tag_ff  <= tag_in;
      end
   end

   assign head_prio = prio_ff[0];
   assign head_tag  = tag_ff[0];

endmodule

[rtl/sorted_priority_queue.sv]
// A result is registered and appears in the cycle after its request transfer.
// Every slot compares and shifts in one step; one request per cycle unless stalled.
// The output register lets a new request in while the result is being taken.
// Reset (synchronous, active high) empties the queue and drops any pending result;
// slot contents are not cleared, only slots below the count are ever read.
`timescale 1ns / 1ps

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int PRIO_BITS = 8,
   parameter int TAG_BITS  = 16,
   localparam int CW       = $clog2(DEPTH + 1),
   localparam int REQ_BITS = PRIO_BITS + TAG_BITS,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = 4 + PRIO_BITS + TAG_BITS + CW,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // priority_req, client_tag, zero pad
   input  logic [1:0]       req_tuser,   // mode
   // result channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // ok, head_valid, head_priority, head_tag,
                                         // count, full_res, empty_res, zero pad
);

   cmd_type              dp_cmd;
   logic [CW-1:0]        count;
   logic                 rsp_ok, full, empty;
   logic [PRIO_BITS-1:0] slot_prio, head_prio;
   logic [TAG_BITS-1:0]  slot_tag, head_tag;

   // sequencing, count and the result register
   spq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_mode (req_tuser),
      .req_ready(req_tready),
      .rsp_ready(rsp_tready),
      .rsp_valid(rsp_tvalid),
      .rsp_ok   (rsp_ok),
      .count    (count),
      .full     (full),
      .empty    (empty),
      .dp_cmd   (dp_cmd)
   );

   // sorted slot array; head always at slot 0
   spq_datapath #(
      .DEPTH    (DEPTH),
      .PRIO_BITS(PRIO_BITS),
      .TAG_BITS (TAG_BITS)
   ) u_dp (
      .clock    (clock),
      .dp_cmd   (dp_cmd),
      .count    (count),
      .req_prio (req_tdata[PRIO_BITS-1:0]),
      .req_tag  (req_tdata[REQ_BITS-1:PRIO_BITS]),
      .head_prio(slot_prio),
      .head_tag (slot_tag)
   );

   // slots only change on a transfer, when the result register is reloaded as well,
   // so the head read straight off slot 0 stays matched to the pending result
   assign head_prio = empty ? '0 : slot_prio;
   assign head_tag  = empty ? '0 : slot_tag;

   assign rsp_tdata = RSP_W'({empty, full, count, head_tag, head_prio, !empty, rsp_ok});

endmodule

[rtl/spq_checker.sv]
`timescale 1ns / 1ps
`include "sorted_priority_queue_assert.svh"

module spq_checker #(
   parameter int DEPTH     = 16,
   parameter int PRIO_BITS = 8,
   parameter int TAG_BITS  = 16,
   localparam int CW       = $clog2(DEPTH + 1),
   localparam int RSP_BITS = 4 + PRIO_BITS + TAG_BITS + CW,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   localparam int HV_BIT    = 1;
   localparam int EMPTY_BIT = 3 + PRIO_BITS + TAG_BITS + CW;

   logic [PRIO_BITS-1:0] rsp_head_prio;
   assign rsp_head_prio = rsp_tdata[PRIO_BITS+1:2];

   `SPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `SPQ_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_tvalid && req_tready,
      rsp_tvalid, "request transfer without result next cycle")
   `SPQ_ASSERT_NOW(a_ready_when_free, clock, reset, !rsp_tvalid,
      req_tready, "request refused with result register free")
   `SPQ_ASSERT_NOW(a_empty_head, clock, reset, rsp_tvalid && rsp_tdata[EMPTY_BIT],
      !rsp_tdata[HV_BIT] && (rsp_head_prio == '0), "empty queue reports a head")

endmodule

bind sorted_priority_queue spq_checker #(
   .DEPTH    (DEPTH),
   .PRIO_BITS(PRIO_BITS),
   .TAG_BITS (TAG_BITS)
) u_spq_checker (.*);
